[sv/css_pkg.sv]
package css_pkg;

  localparam int unsigned CMD_W    = 4;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned WIDE_W   = 64;

  typedef enum logic [CMD_W-1:0] {
    CMD_START       = 4'd0,
    CMD_END         = 4'd1,
    CMD_ADVANCE     = 4'd2,
    CMD_RETREAT     = 4'd3,
    CMD_INSERT      = 4'd4,
    CMD_ATTACH      = 4'd5,
    CMD_REMOVE      = 4'd6,
    CMD_PUSH_FRONT  = 4'd7,
    CMD_PUSH_BACK   = 4'd8,
    CMD_POP_FRONT   = 4'd9,
    CMD_READ_CURSOR = 4'd10,
    CMD_READ_INDEX  = 4'd11
  } css_cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_NO_ITEM = 2'd2,
    STATUS_RANGE   = 2'd3
  } css_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT_UP,
    ST_SHIFT_DN,
    ST_DRAIN,
    ST_WRITE,
    ST_READ,
    ST_FINISH
  } css_state_e;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [VALUE_W-1:0] entry_value;
    logic [POS_W-1:0]   read_position;
  } css_cmd_t;

  typedef struct packed {
    logic [VALUE_W-1:0] read_data;
    logic [COUNT_W-1:0] item_count;
    logic [COUNT_W-1:0] cursor_position;
    logic               cursor_valid;
    css_status_e        status;
  } css_res_t;

endpackage

[sv/css_if.sv]
interface css_cmd_if;
  logic                 valid;
  logic                 ready;
  css_pkg::css_cmd_t    payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface css_res_if;
  logic                 valid;
  logic                 ready;
  css_pkg::css_res_t    payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[sv/css_ram.sv]
module css_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[sv/cursor_sequence_store.sv]
// Ordered store of up to DEPTH words with a cursor, held in one synchronous RAM.
// Commands arrive as beats on cmd_i (cmd, entry_value, read_position); each
// command yields exactly one result beat on res_o (read_data, item_count,
// cursor_position, cursor_valid, status).
// A command is taken only while the sequencer is idle. Cursor moves, failed
// commands and removals that move no entry go straight to the finish state,
// which stores the result; reads and writes that move no entry pass through a
// read or write state first. Insertions and removals move every entry behind
// the gap one place through the RAM, one entry per cycle with one read and one
// write in flight, then drain the last write; an insertion then writes the new
// entry. The next command is accepted once the result is stored and the
// sequencer is idle again, so how long a command occupies the store is set by
// the number of entries moved through the single shared RAM port pair.
// Reset empties the store and sets the cursor to zero at once; the RAM is not
// cleared, as no command ever reads a slot that was not written.
// The result register decouples the two sides: once a result is stored the
// next command is accepted even if the receiver stalls. A second result waits
// in the sequencer until the result register is free.
module cursor_sequence_store #(
  parameter int unsigned DEPTH     = 64,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  css_cmd_if.sink          cmd_i,
  css_res_if.source        res_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  css_pkg::css_state_e  state_q, state_d;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        cursor_q, cursor_d;
  logic [AW-1:0]        idx_q, idx_d;
  logic [AW-1:0]        end_q, end_d;
  logic [AW-1:0]        gap_q, gap_d;
  logic [AW-1:0]        waddr_q, waddr_d;
  logic                 wpend_q, wpend_d;
  logic                 ins_q, ins_d;
  logic                 rd_flag_q, rd_flag_d;
  logic [WORD_BITS-1:0] word_q, word_d;
  css_pkg::css_status_e status_q, status_d;
  logic                 res_valid_q, res_valid_d;
  css_pkg::css_res_t    res_q, res_d;

  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

  logic                 has_item, full;
  logic [AW-1:0]        count_a, cursor_a, last_a, g;
  logic                 op_ins, op_rem, op_rd;
  logic [15:0]          pos_w, cnt_w;
  logic [css_pkg::WIDE_W-1:0] in_wide, rd_wide;

  assign has_item = cursor_q < count_q;
  assign full     = count_q == FULL_COUNT;
  assign count_a  = count_q[AW-1:0];
  assign cursor_a = cursor_q[AW-1:0];
  assign last_a   = count_a - AW'(1);
  assign pos_w    = 16'(cmd_i.payload.read_position);
  assign cnt_w    = 16'(count_q);

  assign cmd_i.ready = (state_q == css_pkg::ST_IDLE);
  assign res_o.valid   = res_valid_q;
  assign res_o.payload = res_q;

  always_comb begin
    in_wide = '0;
    in_wide[css_pkg::VALUE_W-1:0] = cmd_i.payload.entry_value;
    rd_wide = '0;
    rd_wide[WORD_BITS-1:0] = ram_rdata;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    cursor_d    = cursor_q;
    idx_d       = idx_q;
    end_d       = end_q;
    gap_d       = gap_q;
    waddr_d     = waddr_q;
    wpend_d     = 1'b0;
    ins_d       = ins_q;
    rd_flag_d   = rd_flag_q;
    word_d      = word_q;
    status_d    = status_q;
    res_valid_d = res_valid_q && !res_o.ready;
    res_d       = res_q;
    op_ins      = 1'b0;
    op_rem      = 1'b0;
    op_rd       = 1'b0;
    g           = '0;

    unique case (state_q)
      css_pkg::ST_IDLE: begin
        if (cmd_i.valid) begin
          word_d    = in_wide[WORD_BITS-1:0];
          status_d  = css_pkg::STATUS_OK;
          rd_flag_d = 1'b0;
          unique case (cmd_i.payload.cmd)
            css_pkg::CMD_START: cursor_d = '0;
            css_pkg::CMD_END: cursor_d = (count_q != '0) ? count_q - CW'(1) : '0;
            css_pkg::CMD_ADVANCE: begin
              if (has_item) cursor_d = cursor_q + CW'(1);
              else status_d = css_pkg::STATUS_NO_ITEM;
            end
            css_pkg::CMD_RETREAT: begin
              if (!has_item) status_d = css_pkg::STATUS_NO_ITEM;
              else if (cursor_q != '0) cursor_d = cursor_q - CW'(1);
            end
            css_pkg::CMD_INSERT: begin
              if (full) status_d = css_pkg::STATUS_FULL;
              else begin
                op_ins   = 1'b1;
                g        = has_item ? cursor_a : '0;
                cursor_d = CW'(g);
                count_d  = count_q + CW'(1);
              end
            end
            css_pkg::CMD_ATTACH: begin
              if (full) status_d = css_pkg::STATUS_FULL;
              else begin
                op_ins   = 1'b1;
                g        = has_item ? cursor_a + AW'(1) : count_a;
                cursor_d = CW'(g);
                count_d  = count_q + CW'(1);
              end
            end
            css_pkg::CMD_REMOVE: begin
              if (!has_item) status_d = css_pkg::STATUS_NO_ITEM;
              else begin
                op_rem  = 1'b1;
                g       = cursor_a;
                count_d = count_q - CW'(1);
              end
            end
            css_pkg::CMD_PUSH_FRONT: begin
              if (full) status_d = css_pkg::STATUS_FULL;
              else begin
                op_ins  = 1'b1;
                count_d = count_q + CW'(1);
              end
            end
            css_pkg::CMD_PUSH_BACK: begin
              if (full) status_d = css_pkg::STATUS_FULL;
              else begin
                op_ins   = 1'b1;
                g        = count_a;
                cursor_d = count_q;
                count_d  = count_q + CW'(1);
              end
            end
            css_pkg::CMD_POP_FRONT: begin
              if (!has_item) status_d = css_pkg::STATUS_NO_ITEM;
              else begin
                op_rem   = 1'b1;
                count_d  = count_q - CW'(1);
                cursor_d = (cursor_q == '0) ? count_q - CW'(1) : cursor_q - CW'(1);
              end
            end
            css_pkg::CMD_READ_CURSOR: begin
              if (has_item) begin
                op_rd = 1'b1;
                g     = cursor_a;
              end else status_d = css_pkg::STATUS_NO_ITEM;
            end
            css_pkg::CMD_READ_INDEX: begin
              if (pos_w < cnt_w) begin
                op_rd = 1'b1;
                g     = pos_w[AW-1:0];
              end else status_d = css_pkg::STATUS_RANGE;
            end
            default: ;
          endcase

          gap_d = g;
          ins_d = op_ins;
          if (op_ins) begin
            if (g == count_a) state_d = css_pkg::ST_WRITE;
            else begin
              state_d = css_pkg::ST_SHIFT_UP;
              idx_d   = count_a;
              end_d   = g;
            end
          end else if (op_rem) begin
            if (g == last_a) state_d = css_pkg::ST_FINISH;
            else begin
              state_d = css_pkg::ST_SHIFT_DN;
              idx_d   = g + AW'(1);
              end_d   = last_a;
            end
          end else if (op_rd) begin
            state_d   = css_pkg::ST_READ;
            rd_flag_d = 1'b1;
          end else begin
            state_d = css_pkg::ST_FINISH;
          end
        end
      end
      css_pkg::ST_SHIFT_UP: begin
        wpend_d = 1'b1;
        waddr_d = idx_q;
        idx_d   = idx_q - AW'(1);
        if (idx_q - AW'(1) == end_q) state_d = css_pkg::ST_DRAIN;
      end
      css_pkg::ST_SHIFT_DN: begin
        wpend_d = 1'b1;
        waddr_d = idx_q - AW'(1);
        idx_d   = idx_q + AW'(1);
        if (idx_q == end_q) state_d = css_pkg::ST_DRAIN;
      end
      css_pkg::ST_DRAIN: state_d = ins_q ? css_pkg::ST_WRITE : css_pkg::ST_FINISH;
      css_pkg::ST_WRITE: state_d = css_pkg::ST_FINISH;
      css_pkg::ST_READ: state_d = css_pkg::ST_FINISH;
      css_pkg::ST_FINISH: begin
        if (!res_valid_q || res_o.ready) begin
          res_valid_d           = 1'b1;
          res_d.read_data       = rd_flag_q ? rd_wide[css_pkg::VALUE_W-1:0] : '0;
          res_d.item_count      = css_pkg::COUNT_W'(count_q);
          res_d.cursor_position = css_pkg::COUNT_W'(cursor_q);
          res_d.cursor_valid    = has_item;
          res_d.status          = status_q;
          state_d               = css_pkg::ST_IDLE;
        end
      end
      default: state_d = css_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ram_we    = wpend_q || (state_q == css_pkg::ST_WRITE);
    ram_waddr = wpend_q ? waddr_q : gap_q;
    ram_wdata = wpend_q ? ram_rdata : word_q;
    ram_re    = 1'b0;
    ram_raddr = gap_q;
    unique case (state_q)
      css_pkg::ST_SHIFT_UP: begin
        ram_re    = 1'b1;
        ram_raddr = idx_q - AW'(1);
      end
      css_pkg::ST_SHIFT_DN: begin
        ram_re    = 1'b1;
        ram_raddr = idx_q;
      end
      css_pkg::ST_READ: ram_re = 1'b1;
      default: ;
    endcase
  end

  css_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= css_pkg::ST_IDLE;
      count_q     <= '0;
      cursor_q    <= '0;
      wpend_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cursor_q    <= cursor_d;
      wpend_q     <= wpend_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    end_q     <= end_d;
    gap_q     <= gap_d;
    waddr_q   <= waddr_d;
    ins_q     <= ins_d;
    rd_flag_q <= rd_flag_d;
    word_q    <= word_d;
    status_q  <= status_d;
    res_q     <= res_d;
  end

endmodule

[sv/css_check.sv]
module css_check #(
  parameter int unsigned DEPTH = 64
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input css_pkg::css_res_t out_payload_i
);

  localparam bit COUNT_FITS = DEPTH < 128;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_payload_i))
    else $error("Result beat dropped or changed while stalled.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("Command accepted while the previous one was still in work.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && COUNT_FITS |->
      out_payload_i.cursor_valid ==
        (out_payload_i.cursor_position < out_payload_i.item_count))
    else $error("Cursor valid flag disagrees with cursor and count.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && COUNT_FITS && out_payload_i.status == css_pkg::STATUS_FULL |->
      32'(out_payload_i.item_count) == 32'(DEPTH))
    else $error("Full status reported on a store that is not full.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_payload_i.status == css_pkg::STATUS_NO_ITEM ||
                    out_payload_i.status == css_pkg::STATUS_RANGE) |->
      out_payload_i.read_data == '0)
    else $error("Failed command returned read data.");

endmodule

bind cursor_sequence_store css_check #(
  .DEPTH (DEPTH)
) u_css_check (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (cmd_i.valid),
  .in_ready_i    (cmd_i.ready),
  .out_valid_i   (res_o.valid),
  .out_ready_i   (res_o.ready),
  .out_payload_i (res_o.payload)
);
